// ===== rtl/core/bvs_pkg.sv =====
// types and constants for the battery voltage supervisor
// no dependencies; imported by battery_voltage_supervisor
`default_nettype none

package bvs_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_RESTORE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        MODE_OK        = 3'd0,
        MODE_LOW_PEND  = 3'd1,
        MODE_HIGH_PEND = 3'd2,
        MODE_LOW       = 3'd3,
        MODE_HIGH      = 3'd4,
        MODE_HIGH_WAKE = 3'd5,
        MODE_LOW_REC   = 3'd6,
        MODE_HIGH_REC  = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        REG_LOW_THRESHOLD  = 3'd0,
        REG_HIGH_THRESHOLD = 3'd1,
        REG_ENTRY_TOL      = 3'd2,
        REG_RECOVERY_OFS   = 3'd3,
        REG_LOW_DEBOUNCE   = 3'd4,
        REG_HIGH_DEBOUNCE  = 3'd5,
        REG_STOP_PRIORITY  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] raw_sample;
        logic        saved_low_flag;
        logic        saved_high_flag;
    } in_item_t;

    typedef struct packed {
        logic [7:0] filtered_voltage;
        logic       low_fault;
        logic       high_fault;
        logic       motor_stop;
        logic [2:0] supervisor_state;
    } out_item_t;

    localparam int          RAW_W       = 12;
    localparam logic [11:0] RAW_SAT     = 12'd911;
    // floor(raw*272/1000) == (raw*17826)>>16 for raw below 911
    localparam logic [14:0] SCALE_RECIP = 15'd17826;
    localparam logic [7:0]  SCALE_ADD   = 8'd7;
    localparam logic [7:0]  SAT_VALUE   = 8'd255;

    localparam logic [7:0]  BIG_STEP    = 8'd10;
    localparam logic [7:0]  MID_STEP    = 8'd5;
    localparam logic [7:0]  SMALL_STEP  = 8'd2;
    localparam logic [15:0] MID_INC     = 16'd8;
    localparam logic [15:0] SMALL_INC   = 16'd1;
    localparam logic [15:0] RESTORE_TICKS = 16'd3;

    localparam logic [15:0] ACC_RESET   = 16'd2240;

    localparam logic [7:0]  LOW_THRESHOLD_RST  = 8'd86;
    localparam logic [7:0]  HIGH_THRESHOLD_RST = 8'd164;
    localparam logic [7:0]  ENTRY_TOL_RST      = 8'd1;
    localparam logic [7:0]  RECOVERY_OFS_RST   = 8'd1;
    localparam logic [15:0] LOW_DEBOUNCE_RST   = 16'd500;
    localparam logic [15:0] HIGH_DEBOUNCE_RST  = 16'd250;
    localparam logic [15:0] STOP_PRIORITY_RST  = 16'd0;

endpackage

`default_nettype wire

// ===== rtl/core/battery_voltage_supervisor.sv =====
// battery voltage supervisor: sample scaling, step filter, fault state machine
// depends on bvs_pkg
// accepted transactions pass the scaling register, then the result register;
// throughput: one transaction per cycle unless m_ready stalls; the filter and
// state update of one transaction fit the single stage between the scaling and
// result registers, so back-to-back transactions see each other's state
// reset (aresetn low, synchronous): registers at defaults, filter at 140,
// supervisor ok, flags and timer cleared, pipeline empty
`default_nettype none

module battery_voltage_supervisor
    import bvs_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int          USED_W   = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam logic [11:0] RAW_MASK = 12'((32'd1 << USED_W) - 32'd1);

    // configuration registers
    logic [7:0]  low_thr_reg;
    logic [7:0]  high_thr_reg;
    logic [7:0]  entry_tol_reg;
    logic [7:0]  recovery_ofs_reg;
    logic [15:0] low_deb_reg;
    logic [15:0] high_deb_reg;
    logic [15:0] stop_pri_reg;

    logic        cfg_write;
    reg_index_t  cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg      <= LOW_THRESHOLD_RST;
            high_thr_reg     <= HIGH_THRESHOLD_RST;
            entry_tol_reg    <= ENTRY_TOL_RST;
            recovery_ofs_reg <= RECOVERY_OFS_RST;
            low_deb_reg      <= LOW_DEBOUNCE_RST;
            high_deb_reg     <= HIGH_DEBOUNCE_RST;
            stop_pri_reg     <= STOP_PRIORITY_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_LOW_THRESHOLD:  low_thr_reg      <= pwdata[7:0];
                REG_HIGH_THRESHOLD: high_thr_reg     <= pwdata[7:0];
                REG_ENTRY_TOL:      entry_tol_reg    <= pwdata[7:0];
                REG_RECOVERY_OFS:   recovery_ofs_reg <= pwdata[7:0];
                REG_LOW_DEBOUNCE:   low_deb_reg      <= pwdata[15:0];
                REG_HIGH_DEBOUNCE:  high_deb_reg     <= pwdata[15:0];
                REG_STOP_PRIORITY:  stop_pri_reg     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LOW_THRESHOLD:  prdata = {24'd0, low_thr_reg};
            REG_HIGH_THRESHOLD: prdata = {24'd0, high_thr_reg};
            REG_ENTRY_TOL:      prdata = {24'd0, entry_tol_reg};
            REG_RECOVERY_OFS:   prdata = {24'd0, recovery_ofs_reg};
            REG_LOW_DEBOUNCE:   prdata = {16'd0, low_deb_reg};
            REG_HIGH_DEBOUNCE:  prdata = {16'd0, high_deb_reg};
            REG_STOP_PRIORITY:  prdata = {16'd0, stop_pri_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic st1_valid_reg;
    logic m_valid_reg;
    logic adv2;

    assign adv2    = st1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~st1_valid_reg | adv2;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                st1_valid_reg <= s_valid;
            end
            if (adv2) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // stage 1: scale raw sample to volts
    logic [11:0] raw_used;
    logic [24:0] scale_prod;
    logic [7:0]  scaled;

    assign raw_used   = s_data.raw_sample & RAW_MASK;
    assign scale_prod = 25'(raw_used[9:0]) * 25'(SCALE_RECIP);
    assign scaled     = (raw_used >= RAW_SAT) ? SAT_VALUE : (scale_prod[23:16] + SCALE_ADD);

    logic [1:0] st1_op_reg;
    logic [7:0] st1_sample_reg;
    logic       st1_low_reg;
    logic       st1_high_reg;

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            st1_op_reg     <= s_data.operation;
            st1_sample_reg <= scaled;
            st1_low_reg    <= s_data.saved_low_flag;
            st1_high_reg   <= s_data.saved_high_flag;
        end
    end

    // stage 2: filter and supervisor state
    logic [15:0] acc_reg, acc_next;
    logic [15:0] timer_reg, timer_next;
    mode_t       mode_reg, mode_next;
    logic        low_flag_reg, low_flag_next;
    logic        high_flag_reg, high_flag_next;
    logic        stop_reg, stop_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= ACC_RESET;
            timer_reg     <= 16'd0;
            mode_reg      <= MODE_OK;
            low_flag_reg  <= 1'b0;
            high_flag_reg <= 1'b0;
            stop_reg      <= 1'b0;
        end else if (adv2) begin
            acc_reg       <= acc_next;
            timer_reg     <= timer_next;
            mode_reg      <= mode_next;
            low_flag_reg  <= low_flag_next;
            high_flag_reg <= high_flag_next;
            stop_reg      <= stop_next;
        end
    end

    logic [7:0]  smp;
    logic [7:0]  fv_cur;
    logic [7:0]  fv0;
    logic [15:0] acc0;
    logic [7:0]  diff;
    logic [15:0] step;
    logic [15:0] acc_filt;
    logic [7:0]  fv_new;
    logic        below;
    logic        above;
    logic        low_clear;
    logic        high_clear;

    assign smp    = st1_sample_reg;
    assign fv_cur = acc_reg[11:4];
    assign fv0    = (fv_cur == 8'd0) ? smp : fv_cur;
    assign acc0   = (fv_cur == 8'd0) ? {4'd0, smp, 4'd0} : acc_reg;
    assign diff   = (fv0 < smp) ? (smp - fv0) : (fv0 - smp);

    always_comb begin
        if (diff >= BIG_STEP) begin
            step = {8'd0, smp};
        end else if (diff >= MID_STEP) begin
            step = MID_INC;
        end else if (diff >= SMALL_STEP) begin
            step = SMALL_INC;
        end else begin
            step = 16'd0;
        end
    end

    assign acc_filt = (fv0 < smp) ? (acc0 + step) : (acc0 - step);
    assign fv_new   = acc_filt[11:4];

    // threshold limits without wrap, in 9 bits
    assign below      = ({1'b0, fv_new} + {1'b0, entry_tol_reg}) < {1'b0, low_thr_reg};
    assign above      = {1'b0, fv_new} > ({1'b0, high_thr_reg} + {1'b0, entry_tol_reg});
    assign low_clear  = {1'b0, fv_new} > ({1'b0, low_thr_reg} + {1'b0, recovery_ofs_reg});
    assign high_clear = ({1'b0, fv_new} + {1'b0, recovery_ofs_reg}) < {1'b0, high_thr_reg};

    always_comb begin
        acc_next       = acc_reg;
        timer_next     = timer_reg;
        mode_next      = mode_reg;
        low_flag_next  = low_flag_reg;
        high_flag_next = high_flag_reg;
        stop_next      = stop_reg;
        case (st1_op_reg)
            OP_TICK: begin
                if (timer_reg != 16'd0) begin
                    timer_next = timer_reg - 16'd1;
                end
            end
            OP_SAMPLE: begin
                acc_next = acc_filt;
                case (mode_reg)
                    MODE_OK: begin
                        if (below) begin
                            timer_next = low_deb_reg;
                            mode_next  = MODE_LOW_PEND;
                        end else if (above) begin
                            timer_next = high_deb_reg;
                            mode_next  = MODE_HIGH_PEND;
                        end
                    end
                    MODE_LOW_PEND: begin
                        if (!below) begin
                            mode_next = MODE_OK;
                        end else if (timer_reg == 16'd0) begin
                            low_flag_next = 1'b1;
                            mode_next     = MODE_LOW;
                        end
                    end
                    MODE_HIGH_PEND: begin
                        if (!above) begin
                            mode_next = MODE_OK;
                        end else if (timer_reg == 16'd0) begin
                            high_flag_next = 1'b1;
                            mode_next      = MODE_HIGH;
                        end
                    end
                    MODE_LOW, MODE_LOW_REC: begin
                        stop_next = 1'b1;
                        if (!low_clear) begin
                            mode_next = MODE_LOW;
                        end else if (mode_reg == MODE_LOW) begin
                            timer_next = low_deb_reg;
                            mode_next  = MODE_LOW_REC;
                        end else if (timer_reg == 16'd0) begin
                            stop_next     = 1'b0;
                            low_flag_next = 1'b0;
                            mode_next     = MODE_OK;
                        end
                    end
                    MODE_HIGH, MODE_HIGH_REC: begin
                        stop_next = 1'b1;
                        if (!high_clear) begin
                            mode_next = MODE_HIGH;
                        end else if (mode_reg == MODE_HIGH) begin
                            timer_next = high_deb_reg;
                            mode_next  = MODE_HIGH_REC;
                        end else if (timer_reg == 16'd0) begin
                            stop_next      = 1'b0;
                            high_flag_next = 1'b0;
                            mode_next      = MODE_OK;
                        end
                    end
                    MODE_HIGH_WAKE: begin
                        if (timer_reg == 16'd0) begin
                            if (above) begin
                                stop_next = 1'b1;
                                mode_next = MODE_HIGH;
                            end else begin
                                high_flag_next = 1'b0;
                                stop_next      = 1'b0;
                                mode_next      = MODE_OK;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_RESTORE: begin
                low_flag_next  = st1_low_reg;
                high_flag_next = st1_high_reg;
                if (st1_high_reg) begin
                    mode_next  = MODE_HIGH_WAKE;
                    timer_next = RESTORE_TICKS;
                end else if (st1_low_reg) begin
                    mode_next  = MODE_LOW;
                    timer_next = RESTORE_TICKS;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_data_reg.filtered_voltage <= acc_next[11:4];
            m_data_reg.low_fault        <= low_flag_next;
            m_data_reg.high_fault       <= high_flag_next;
            m_data_reg.motor_stop       <= stop_next;
            m_data_reg.supervisor_state <= mode_next;
        end
    end

    assign m_data = m_data_reg;

    // checks
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline is full");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 |=> m_valid)
        else $error("advanced transaction produced no result");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv2 |=> ($stable(mode_reg) && $stable(acc_reg) && $stable(timer_reg)))
        else $error("supervisor state changed without a transaction");

    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv2 && st1_op_reg == OP_TICK && timer_reg != 16'd0)
        |=> (timer_reg == $past(timer_reg) - 16'd1))
        else $error("debounce timer did not count down on tick");

endmodule

`default_nettype wire
